// ===== hw/rtl/visit_record_gini_compactor_top_defines.svh =====
// assertion macros for the visit record gini compactor
// expects clk and rst_n in the scope of each use
`ifndef VISIT_RECORD_GINI_COMPACTOR_TOP_DEFINES_SVH
`define VISIT_RECORD_GINI_COMPACTOR_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define VRGC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define VRGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vrgc_pkg.sv =====
// shared types and constants for the visit record gini compactor
// no dependencies
package vrgc_pkg;

    localparam int HEADER_BYTES_DEF = 43;
    localparam int HDR_CNT_W        = 6;
    localparam int VSUM_W           = 17;
    localparam int SQSUM_W          = 24;
    localparam int S2_W             = 32;
    localparam int NUM_W            = 48;
    localparam int DVD_W            = 50;
    localparam int REM_W            = 33;
    localparam int GINI_W           = 16;
    localparam int QUEUE_DEPTH      = 2;

    typedef logic [1:0] job_kind_t;

    localparam job_kind_t JOB_HDR = 2'd0;
    localparam job_kind_t JOB_END = 2'd1;
    localparam job_kind_t JOB_POS = 2'd2;

    typedef struct packed {
        job_kind_t            kind;
        logic [15:0]          move_word;
        logic [15:0]          score_word;
        logic [VSUM_W-1:0]    visit_sum;
        logic [SQSUM_W-1:0]   square_sum;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } qstat_t;

endpackage

// ===== hw/rtl/vrgc_front.sv =====
// byte parser: splits the stream into header bytes, game ends and positions
// depends on vrgc_pkg
module vrgc_front #(
    parameter int HEADER_BYTES = vrgc_pkg::HEADER_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      in_byte,
    input  vrgc_pkg::qstat_t q_stat,
    output logic            push,
    output vrgc_pkg::job_t  push_job
);
    import vrgc_pkg::*;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_MOVE_LO  = 3'd1;
    localparam logic [2:0] PH_MOVE_HI  = 3'd2;
    localparam logic [2:0] PH_SCORE_LO = 3'd3;
    localparam logic [2:0] PH_SCORE_HI = 3'd4;
    localparam logic [2:0] PH_COUNT    = 3'd5;
    localparam logic [2:0] PH_VISITS   = 3'd6;

    localparam logic [HDR_CNT_W-1:0] HDR_INIT = HDR_CNT_W'(HEADER_BYTES);

    logic [2:0]           phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] header_left_reg, header_left_next;
    logic [7:0]           visits_left_reg, visits_left_next;
    logic [15:0]          move_reg, move_next;
    logic [15:0]          score_reg, score_next;
    logic [VSUM_W-1:0]    vsum_reg, vsum_next;
    logic [SQSUM_W-1:0]   sq_reg, sq_next;

    logic                 accept;
    logic [15:0]          byte_sq;
    logic [VSUM_W-1:0]    vsum_add;
    logic [SQSUM_W-1:0]   sq_add;
    logic [HDR_CNT_W-1:0] hl_base;
    logic [HDR_CNT_W-1:0] hl_dec;
    logic [15:0]          move_full;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign byte_sq  = 16'(in_byte) * 16'(in_byte);
    assign vsum_add = vsum_reg + VSUM_W'(in_byte);
    assign sq_add   = sq_reg + SQSUM_W'(byte_sq);
    // an unused phase code restarts the header count
    assign hl_base  = (phase_reg == PH_HEADER) ? header_left_reg : HDR_INIT;
    assign hl_dec   = hl_base - HDR_CNT_W'(1);
    assign move_full = {in_byte, move_reg[7:0]};

    always_comb
    begin
        phase_next       = phase_reg;
        header_left_next = header_left_reg;
        visits_left_next = visits_left_reg;
        move_next        = move_reg;
        score_next       = score_reg;
        vsum_next        = vsum_reg;
        sq_next          = sq_reg;
        push             = 1'b0;
        push_job         = '0;
        push_job.move_word  = move_reg;
        push_job.score_word = score_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_MOVE_LO:
                begin
                    move_next  = {move_reg[15:8], in_byte};
                    phase_next = PH_MOVE_HI;
                end
                PH_MOVE_HI:
                begin
                    move_next = move_full;
                    if (move_full == 16'd0)
                    begin
                        push             = 1'b1;
                        push_job.kind    = JOB_END;
                        phase_next       = PH_HEADER;
                        header_left_next = HDR_INIT;
                    end
                    else
                    begin
                        phase_next = PH_SCORE_LO;
                    end
                end
                PH_SCORE_LO:
                begin
                    score_next = {score_reg[15:8], in_byte};
                    phase_next = PH_SCORE_HI;
                end
                PH_SCORE_HI:
                begin
                    score_next = {in_byte, score_reg[7:0]};
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    vsum_next        = '0;
                    sq_next          = '0;
                    visits_left_next = in_byte;
                    if (in_byte == 8'd0)
                    begin
                        push                = 1'b1;
                        push_job.kind       = JOB_POS;
                        push_job.visit_sum  = '0;
                        push_job.square_sum = '0;
                        phase_next          = PH_MOVE_LO;
                    end
                    else
                    begin
                        phase_next = PH_VISITS;
                    end
                end
                PH_VISITS:
                begin
                    vsum_next        = vsum_add;
                    sq_next          = sq_add;
                    visits_left_next = visits_left_reg - 8'd1;
                    if (visits_left_reg == 8'd1)
                    begin
                        push                = 1'b1;
                        push_job.kind       = JOB_POS;
                        push_job.visit_sum  = vsum_add;
                        push_job.square_sum = sq_add;
                        phase_next          = PH_MOVE_LO;
                    end
                end
                default:
                begin
                    push               = 1'b1;
                    push_job.kind      = JOB_HDR;
                    push_job.move_word = {8'd0, in_byte};
                    header_left_next   = hl_dec;
                    phase_next         = (hl_dec == '0) ? PH_MOVE_LO : PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            header_left_reg <= HDR_INIT;
            visits_left_reg <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            header_left_reg <= header_left_next;
            visits_left_reg <= visits_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        move_reg  <= move_next;
        score_reg <= score_next;
        vsum_reg  <= vsum_next;
        sq_reg    <= sq_next;
    end

endmodule

// ===== hw/rtl/vrgc_queue.sv =====
// small request queue between the parser and the output engine
// depends on vrgc_pkg
module vrgc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vrgc_pkg::job_t   push_job,
    input  logic             pop,
    output vrgc_pkg::job_t   pop_job,
    output vrgc_pkg::qstat_t q_stat
);
    import vrgc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_stat.full     = (count_reg == CNT_FULL);
    assign q_stat.nonempty = (count_reg != '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.nonempty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/vrgc_back.sv =====
// output engine: gini by a bit-serial divider, then byte emission
// depends on vrgc_pkg
module vrgc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  vrgc_pkg::qstat_t q_stat,
    output logic             pop,
    input  vrgc_pkg::job_t   pop_job,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             game_end
);
    import vrgc_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DIFF = 3'd2;
    localparam logic [2:0] B_NUM  = 3'd3;
    localparam logic [2:0] B_DVD  = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_EMIT = 3'd6;

    localparam logic [2:0] BI_MOVE_LO  = 3'd0;
    localparam logic [2:0] BI_MOVE_HI  = 3'd1;
    localparam logic [2:0] BI_SCORE_LO = 3'd2;
    localparam logic [2:0] BI_SCORE_HI = 3'd3;
    localparam logic [2:0] BI_GINI_LO  = 3'd4;
    localparam logic [2:0] BI_GINI_HI  = 3'd5;

    localparam int STEP_W = $clog2(GINI_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GINI_W - 1);

    logic [2:0]        state_reg, state_next;
    job_t              job_reg, job_next;
    logic [S2_W-1:0]   s2_reg, s2_next;
    logic [S2_W-1:0]   diff_reg, diff_next;
    logic              zero_reg, zero_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [GINI_W-1:0] dlo_reg, dlo_next;
    logic [GINI_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        idx_reg, idx_next;
    logic [2:0]        last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              run_last_reg, run_last_next;
    logic              game_end_reg, game_end_next;

    logic [2*VSUM_W-1:0] prod_full;
    logic [DVD_W-1:0]    dvd;
    logic [REM_W:0]      trial;
    logic [REM_W:0]      divisor;
    logic [REM_W:0]      trial_sub;
    logic                trial_ge;
    logic [GINI_W-1:0]   gini;
    logic                out_free;
    logic [7:0]          sel_byte;

    assign prod_full = (2*VSUM_W)'(job_reg.visit_sum) * (2*VSUM_W)'(job_reg.visit_sum);
    // dividend is 2*num + s2, divisor 2*s2: rounds half up
    assign dvd       = DVD_W'({num_reg, 1'b0}) + DVD_W'(s2_reg);
    assign divisor   = (REM_W + 1)'({s2_reg, 1'b0});
    assign trial     = {rem_reg, dlo_reg[GINI_W-1]};
    assign trial_sub = trial - divisor;
    assign trial_ge  = (trial >= divisor);
    assign gini      = zero_reg ? '0 : quo_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (idx_reg)
            BI_MOVE_LO:  sel_byte = job_reg.move_word[7:0];
            BI_MOVE_HI:  sel_byte = job_reg.move_word[15:8];
            BI_SCORE_LO: sel_byte = job_reg.score_word[7:0];
            BI_SCORE_HI: sel_byte = job_reg.score_word[15:8];
            BI_GINI_LO:  sel_byte = gini[7:0];
            BI_GINI_HI:  sel_byte = gini[15:8];
            default:     sel_byte = 8'd0;
        endcase
        if (job_reg.kind == JOB_END)
        begin
            sel_byte = 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        s2_next        = s2_reg;
        diff_next      = diff_reg;
        zero_next      = zero_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dlo_next       = dlo_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        game_end_next  = game_end_reg;
        pop            = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_stat.nonempty)
                begin
                    pop      = 1'b1;
                    job_next = pop_job;
                    idx_next = BI_MOVE_LO;
                    if (pop_job.kind == JOB_POS)
                    begin
                        state_next = B_MUL;
                    end
                    else if (pop_job.kind == JOB_END)
                    begin
                        last_next  = BI_MOVE_HI;
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        last_next  = BI_MOVE_LO;
                        state_next = B_EMIT;
                    end
                end
            end
            B_MUL:
            begin
                s2_next    = prod_full[S2_W-1:0];
                state_next = B_DIFF;
            end
            B_DIFF:
            begin
                diff_next  = s2_reg - S2_W'(job_reg.square_sum);
                zero_next  = (job_reg.visit_sum == '0) ||
                             (S2_W'(job_reg.square_sum) > s2_reg);
                state_next = B_NUM;
            end
            B_NUM:
            begin
                // times 65535 as a shift and a subtract
                num_next   = {diff_reg, 16'd0} - NUM_W'(diff_reg);
                state_next = B_DVD;
            end
            B_DVD:
            begin
                // quotient fits 16 bits, so the upper part is below the divisor
                rem_next   = dvd[DVD_W-2:GINI_W];
                dlo_next   = dvd[GINI_W-1:0];
                quo_next   = '0;
                step_next  = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
                quo_next  = {quo_reg[GINI_W-2:0], trial_ge};
                dlo_next  = {dlo_reg[GINI_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    last_next  = BI_GINI_HI;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = sel_byte;
                    run_last_next  = (idx_reg == last_reg);
                    game_end_next  = (job_reg.kind == JOB_END);
                    idx_next       = idx_reg + 3'd1;
                    if (idx_reg == last_reg)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        s2_reg       <= s2_next;
        diff_reg     <= diff_next;
        zero_reg     <= zero_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        dlo_reg      <= dlo_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
        game_end_reg <= game_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign game_end  = game_end_reg;

endmodule

// ===== hw/rtl/visit_record_gini_compactor_top.sv =====
// top level of the visit record gini compactor
// depends on vrgc_pkg, vrgc_front, vrgc_queue, vrgc_back and the defines header
//
// in channel: one raw byte per request (in_valid, in_stall, in_byte)
// out channel: one compact byte per request (out_valid, out_stall, out_byte,
//   run_last on the final byte caused by an input byte, game_end on the
//   two zero bytes that close a game)
// a header byte is popped in the idle state and written to the output register in
//   the emit state; the engine pops the next request only back in the idle state
// a position runs through one multiply, three setup steps,
//   a 16-step restoring divider for the gini, then six output bytes
// header, move, score, count and visit bytes are taken at one per cycle while
//   the two-entry queue has room; in_stall is high whenever it is full
// out_stall holds the output register; the engine keeps working until it
//   needs that register again
// reset clears the parser to the header phase and empties the queue
//   and the output register
`include "visit_record_gini_compactor_top_defines.svh"

module visit_record_gini_compactor_top #(
    parameter int HEADER_BYTES = vrgc_pkg::HEADER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       game_end
);
    import vrgc_pkg::*;

    qstat_t q_stat;
    logic   push;
    job_t   push_job;
    logic   pop;
    job_t   pop_job;

    vrgc_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    vrgc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    vrgc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_job   (pop_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .game_end  (game_end)
    );

    `VRGC_ASSERT_IMPLIES(a_push_room, push, !q_stat.full, "request pushed into a full queue")
    `VRGC_ASSERT_IMPLIES(a_pop_data, pop, q_stat.nonempty, "request popped from an empty queue")
    `VRGC_ASSERT_NEXT(a_pop_single, pop, !pop, "engine popped two requests in a row")
    `VRGC_ASSERT_IMPLIES(a_end_zero, out_valid && game_end, out_byte == 8'd0, "game end byte not zero")

endmodule

// ===== tb/sv/visit_record_gini_compactor_top_tb.sv =====
`timescale 1ns / 1ps
// testbench for visit_record_gini_compactor_top: game record streams in, compact bytes out
// needs vrgc_pkg and the compactor rtl; a class tracks the parser and queues expected bytes
module visit_record_gini_compactor_top_tb;

    localparam int HDR_LEN        = vrgc_pkg::HEADER_BYTES_DEF;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_BYTES   = 40;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_MOVE_LO  = 3'd1,
        PH_MOVE_HI  = 3'd2,
        PH_SCORE_LO = 3'd3,
        PH_SCORE_HI = 3'd4,
        PH_COUNT    = 3'd5,
        PH_VISITS   = 3'd6
    } parse_phase_t;

    class compact_stream_checker;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
            logic       term;
        } compact_byte_t;

        parse_phase_t  phase;
        logic [5:0]    header_left;
        logic [15:0]   move_word;
        logic [15:0]   score_word;
        logic [7:0]    visits_left;
        logic [16:0]   visit_sum;
        logic [23:0]   square_sum;
        compact_byte_t expected_bytes[$];
        int            errors;

        function new();
            phase       = PH_HEADER;
            header_left = 6'(HDR_LEN);
            move_word   = '0;
            score_word  = '0;
            visits_left = '0;
            visit_sum   = '0;
            square_sum  = '0;
            errors      = 0;
        endfunction

        function int pending_count();
            return expected_bytes.size();
        endfunction

        function void expect_byte(logic [7:0] data, logic term);
            compact_byte_t rec;
            rec.data = data;
            rec.last = 1'b0;
            rec.term = term;
            expected_bytes.insert(expected_bytes.size(), rec);
        endfunction

        // move, score, then gini scaled to 16 bits, rounded half up with exact integers
        function void queue_position_bytes();
            logic [63:0] s;
            logic [63:0] s2;
            logic [63:0] sq;
            logic [63:0] q;
            s  = 64'(visit_sum);
            s2 = s * s;
            sq = 64'(square_sum);
            if (s == 0 || sq > s2)
                q = '0;
            else
            begin
                q = (2 * ((s2 - sq) * 64'd65535) + s2) / (2 * s2);
                if (q > 64'd65535)
                    q = 64'd65535;
            end
            expect_byte(move_word[7:0], 1'b0);
            expect_byte(move_word[15:8], 1'b0);
            expect_byte(score_word[7:0], 1'b0);
            expect_byte(score_word[15:8], 1'b0);
            expect_byte(q[7:0], 1'b0);
            expect_byte(q[15:8], 1'b0);
            phase = PH_MOVE_LO;
        endfunction

        function void take_source_byte(logic [7:0] b);
            int before_n;
            before_n = expected_bytes.size();
            case (phase)
                PH_MOVE_LO:
                begin
                    move_word = {8'h00, b};
                    phase     = PH_MOVE_HI;
                end
                PH_MOVE_HI:
                begin
                    move_word[15:8] = b;
                    if (move_word == 16'h0000)
                    begin
                        expect_byte(8'h00, 1'b1);
                        expect_byte(8'h00, 1'b1);
                        phase       = PH_HEADER;
                        header_left = 6'(HDR_LEN);
                    end
                    else
                        phase = PH_SCORE_LO;
                end
                PH_SCORE_LO:
                begin
                    score_word = {8'h00, b};
                    phase      = PH_SCORE_HI;
                end
                PH_SCORE_HI:
                begin
                    score_word[15:8] = b;
                    phase            = PH_COUNT;
                end
                PH_COUNT:
                begin
                    visit_sum   = '0;
                    square_sum  = '0;
                    visits_left = b;
                    if (b == 8'h00)
                        queue_position_bytes();
                    else
                        phase = PH_VISITS;
                end
                PH_VISITS:
                begin
                    visit_sum   = visit_sum + 17'(b);
                    square_sum  = square_sum + 24'(b) * 24'(b);
                    visits_left = visits_left - 8'd1;
                    if (visits_left == 8'd0)
                        queue_position_bytes();
                end
                default:
                begin
                    // unknown phase codes fall back to a fresh header
                    if (phase != PH_HEADER)
                    begin
                        phase       = PH_HEADER;
                        header_left = 6'(HDR_LEN);
                    end
                    expect_byte(b, 1'b0);
                    header_left = header_left - 6'd1;
                    if (header_left == 6'd0)
                        phase = PH_MOVE_LO;
                end
            endcase
            if (expected_bytes.size() > before_n)
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_compact_byte(logic [7:0] data, logic last, logic term);
            compact_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last %b end %b", data, last, term));
                return;
            end
            want = expected_bytes[0];
            expected_bytes.delete(0);
            if (data !== want.data)
                report($sformatf("out_byte %02h, wanted %02h", data, want.data));
            if (last !== want.last)
                report($sformatf("run_last %b, wanted %b", last, want.last));
            if (term !== want.term)
                report($sformatf("game_end %b, wanted %b", term, want.term));
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       game_end;

    compact_stream_checker board = new();

    bit          gaps_on     = 1'b1;
    bit          hold_now    = 1'b0;
    bit          hold_active = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned random_sent  = 0;

    visit_record_gini_compactor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .game_end  (game_end)
    );

    always #2 clk = ~clk;

    // hold valid and payload until the request goes through, then maybe idle
    task automatic send_byte(input logic [7:0] b);
        int unsigned pick;
        int unsigned gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_source_byte(b);
        random_sent++;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else if (pick < 98)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 40);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_header();
        repeat (HDR_LEN) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_pos_head(input logic [15:0] mv, input logic [15:0] sc,
                                 input logic [7:0] cnt);
        send_byte(mv[7:0]);
        send_byte(mv[15:8]);
        send_byte(sc[7:0]);
        send_byte(sc[15:8]);
        send_byte(cnt);
    endtask

    task automatic send_random_game(input int unsigned npos);
        logic [15:0] mv;
        int unsigned cnt;
        int unsigned vmax;
        int unsigned pick;
        send_random_header();
        for (int p = 0; p < npos; p++)
        begin
            mv = 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 3) == 0)
                mv[7:0] = 8'h00;
            if (mv == 16'h0000)
                mv = 16'h0100;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cnt = 0;
            else if (pick == 9)
                cnt = $urandom_range(9, 40);
            else
                cnt = $urandom_range(1, 8);
            // narrow ranges give ties and all-zero sets
            vmax = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 255;
            send_pos_head(mv, 16'($urandom_range(0, 65535)), 8'(cnt));
            repeat (cnt) send_byte(8'($urandom_range(0, vmax)));
        end
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // sender
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // receiver holds off while the header keeps coming
        hold_now = 1'b1;
        do @(posedge clk); while (!hold_active);

        // directed game: header extremes, then the special positions
        for (int i = 0; i < HDR_LEN; i++)
        begin
            case (i)
                0:       send_byte(8'h00);
                1:       send_byte(8'hff);
                2:       send_byte(8'h55);
                3:       send_byte(8'haa);
                default: send_byte(8'(i * 37));
            endcase
        end
        send_pos_head(16'h0001, 16'hffff, 8'd0);      // empty distribution
        send_pos_head(16'hff00, 16'h0000, 8'd1);      // only zero visits
        send_byte(8'h00);
        send_pos_head(16'hffff, 16'h8001, 8'd2);      // exact half, rounds up
        send_byte(8'h01);
        send_byte(8'h01);
        send_pos_head(16'h1234, 16'h7fff, 8'd3);
        repeat (3) send_byte(8'hff);
        send_pos_head(16'h00ff, 16'h0080, 8'd1);      // single child
        send_byte(8'hff);
        send_pos_head(16'h8000, 16'h0100, 8'd4);
        send_byte(8'h00);
        send_byte(8'h07);
        send_byte(8'h00);
        send_byte(8'hc8);
        send_byte(8'h00);
        send_byte(8'h00);

        // let the block drain completely before going on
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_count() != 0);

        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_game($urandom_range(1, 2));
        end
        gaps_on = 1'b1;

        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_count() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver stall pattern
    initial
    begin
        int unsigned pick;
        wait (rst_n);
        forever
        begin
            pick = $urandom_range(0, 19);
            if (hold_now)
            begin
                hold_now    = 1'b0;
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (pick < 9)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (pick < 15)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (pick < 17)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(40, 120)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_compact_byte(out_byte, run_last, game_end);
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
